// File: design/ssp_pkg.sv
`default_nettype none
package ssp_pkg;

    // Step position width and the circle it wraps on
    localparam int POS_W    = 9;
    localparam int HALF_REV = 256;

    // angle * 512 / 360 = (angle * 64) / 45, done as a multiply by a scaled reciprocal
    localparam int SCALED_W   = 15;
    localparam int RECIP_W    = 16;
    localparam int RECIP_SH   = 21;
    localparam int PROD_W     = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_45 = 16'd46604;

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        OP_SET_TARGET = 2'd0,
        OP_TICK       = 2'd1,
        OP_LOAD_POS   = 2'd2,
        OP_TARGET_POS = 2'd3
    } op_t;

    // Direction codes
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // Result handed from the core to the output sequencer
    typedef struct packed {
        logic             multi;
        logic             dir;
        logic [POS_W-1:0] position;
    } result_t;

    // Coil pattern of one full-step phase
    function automatic logic [3:0] phase_coils(input logic dir, input logic [1:0] phase);
        logic [3:0] coils;
        begin
            coils = 4'd0;
            case (phase)
                2'd0: coils = (dir == DIR_CW) ? 4'b1000 : 4'b0001;
                2'd1: coils = (dir == DIR_CW) ? 4'b0100 : 4'b0010;
                2'd2: coils = (dir == DIR_CW) ? 4'b0010 : 4'b0100;
                2'd3: coils = (dir == DIR_CW) ? 4'b0001 : 4'b1000;
                default: coils = 4'd0;
            endcase
            return coils;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/stepper_shortest_path_positioner.sv
// Shortest-path stepper positioner, full-step drive.
// Input stream (s_*): one word per command. s_tuser carries the operation
// (set target from angle, tick, load position, target equals position);
// s_tdata carries the angle in degrees and the position to load.
// Output stream (m_*): coil pattern, stepped flag and current position;
// m_tlast marks the final word of each command.
// A command accepted into the input register passes to the output register
// once the output sequencer is free. A tick that takes a step yields four
// words, one coil phase per cycle while m_tready is high; every other
// command yields one. Throughput: one command per cycle while results are
// single words and the receiver is ready; a stepping tick holds the input
// until the output sequencer has drained its four phases.
// Reset clears position, target, direction (clockwise) and the armed flag,
// and empties both the input and output registers.
// When the receiver stalls, the current word holds and one more command is
// taken into the input register before s_tready drops.
`default_nettype none
module stepper_shortest_path_positioner
    import ssp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // angle[8:0], new_position[17:9], zero pad
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // coils[3:0], position[12:4], zero pad
    output logic [0:0]       m_tuser,   // stepped[0]
    output logic             m_tlast
);

    logic [POS_W-1:0] goal;
    logic             out_free;
    logic             res_load;
    result_t          res;
    logic [3:0]       coils;
    logic             stepped;
    logic [POS_W-1:0] position;

    ssp_angle_map u_angle_map (
        .angle (s_tdata[8:0]),
        .goal  (goal)
    );

    ssp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_goal    (goal),
        .in_new_pos (s_tdata[17:9]),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    ssp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .coils    (coils),
        .stepped  (stepped),
        .position (position),
        .last     (m_tlast)
    );

    // pack result word
    assign m_tdata = {3'd0, position, coils};
    assign m_tuser = stepped;

endmodule
`default_nettype wire

// File: design/ssp_angle_map.sv
`default_nettype none
module ssp_angle_map
    import ssp_pkg::*;
(
    input  wire logic [8:0]       angle,
    output logic      [POS_W-1:0] goal
);

    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [POS_W-1:0]    steps;

    // floor(angle*64/45) via reciprocal; exact for every 9-bit angle
    assign scaled = {angle, 6'd0};
    assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_45);
    assign steps  = prod[RECIP_SH +: POS_W];

    // target is the negated step count, wrapped to one revolution
    assign goal   = POS_W'(0) - steps;

endmodule
`default_nettype wire

// File: design/ssp_core.sv
`default_nettype none
module ssp_core
    import ssp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [POS_W-1:0] in_goal,
    input  wire logic [POS_W-1:0] in_new_pos,
    input  wire logic             out_free,
    output logic                  res_load,
    output result_t               res
);

    logic             hold_valid_reg;
    op_t              op_reg;
    logic [POS_W-1:0] goal_reg;
    logic [POS_W-1:0] new_pos_reg;

    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] target_reg, target_next;
    logic             dir_reg, dir_next;
    logic             armed_reg, armed_next;
    logic             multi;

    logic             dir1;
    logic [POS_W-1:0] len1;

    assign res_load = hold_valid_reg && out_free;
    assign in_ready = !hold_valid_reg || res_load;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg      <= op_t'(in_op);
            goal_reg    <= in_goal;
            new_pos_reg <= in_new_pos;
        end
    end

    // direct direction and distance to the new goal, without wrapping
    assign dir1 = (goal_reg < position_reg);
    assign len1 = dir1 ? (position_reg - goal_reg) : (goal_reg - position_reg);

    // state update for the held word
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        dir_next      = dir_reg;
        armed_next    = armed_reg;
        multi         = 1'b0;
        case (op_reg)
            OP_SET_TARGET:
            begin
                if (goal_reg != target_reg)
                begin
                    if (len1 < POS_W'(HALF_REV))
                        dir_next = dir1;
                    else if (len1 == POS_W'(HALF_REV))
                        dir_next = DIR_CW;
                    else
                        dir_next = ~dir1;
                end
                target_next = goal_reg;
                armed_next  = 1'b1;
            end
            OP_TICK:
            begin
                if (armed_reg && (target_reg != position_reg))
                begin
                    multi = 1'b1;
                    if (dir_reg == DIR_CW)
                        position_next = position_reg + POS_W'(1);
                    else
                        position_next = position_reg - POS_W'(1);
                end
            end
            OP_LOAD_POS:
            begin
                position_next = new_pos_reg;
            end
            OP_TARGET_POS:
            begin
                target_next = position_reg;
            end
            default:
            begin
                target_next = target_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            target_reg   <= '0;
            dir_reg      <= DIR_CW;
            armed_reg    <= 1'b0;
        end
        else if (res_load)
        begin
            position_reg <= position_next;
            target_reg   <= target_next;
            dir_reg      <= dir_next;
            armed_reg    <= armed_next;
        end
    end

    assign res.multi    = multi;
    assign res.dir      = dir_reg;
    assign res.position = position_next;

endmodule
`default_nettype wire

// File: design/ssp_out.sv
`default_nettype none
module ssp_out
    import ssp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_load,
    input  wire result_t          res,
    output logic                  out_free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [3:0]            coils,
    output logic                  stepped,
    output logic [POS_W-1:0]      position,
    output logic                  last
);

    logic             valid_reg;
    logic [1:0]       phase_reg;
    result_t          res_reg;

    // final word of the current result burst
    assign last     = !res_reg.multi || (phase_reg == 2'd3);
    assign out_free = !valid_reg || (m_ready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 2'd0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 2'd0;
        end
        else if (valid_reg && m_ready)
        begin
            if (last)
                valid_reg <= 1'b0;
            phase_reg <= phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res;
    end

    assign m_valid  = valid_reg;
    assign coils    = res_reg.multi ? phase_coils(res_reg.dir, phase_reg) : 4'd0;
    assign stepped  = res_reg.multi;
    assign position = res_reg.position;

endmodule
`default_nettype wire

// File: tb/tb_stepper_shortest_path_positioner.sv
module tb_stepper_shortest_path_positioner;
    import ssp_pkg::*;

    localparam int REV         = 512;
    localparam int RANDOM_CMDS = 260;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;

    // One command on the input stream
    typedef struct {
        op_t        op;
        logic [8:0] angle;
        logic [8:0] new_pos;
    } cmd_t;

    // One word on the output stream
    typedef struct {
        logic [3:0] coils;
        logic       stepped;
        logic [8:0] position;
        logic       last;
    } coil_word_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_SET_TARGET;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    stepper_shortest_path_positioner u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Command queue, predicted coil words, and the motor state as the predictor sees it
    cmd_t       pending_cmds[$];
    coil_word_t coil_words_due[$];
    cmd_t       cur_cmd;
    logic [8:0] motor_pos;
    logic [8:0] motor_target;
    logic       motor_dir;
    logic       motor_armed;

    logic calm = 1'b0;     // no idling on either side while set
    int   send_wait;
    int   ready_wait;
    int   errors     = 0;
    int   cycles     = 0;
    int   n_cmds     = 0;
    int   n_words    = 0;
    int   n_moves    = 0;
    int   n_queued   = 0;
    int   n_sets     = 0;
    int   n_arrivals = 0;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Angle in degrees to a target step, negated around the circle
    function automatic logic [8:0] angle_to_step(input logic [8:0] angle);
        int steps;
        steps = (int'(angle) * REV) / 360;
        return 9'((REV - (steps % REV)) % REV);
    endfunction

    // Apply one command to the motor state and queue the words it should produce
    task automatic predict_command(input cmd_t c);
        coil_word_t w;
        logic [8:0] goal;
        logic       dir_fwd;
        int         span;
        int         span_wrap;
        w = '{coils: 4'd0, stepped: 1'b0, position: 9'd0, last: 1'b1};
        case (c.op)
            OP_SET_TARGET:
            begin
                goal = angle_to_step(c.angle);
                span = int'(goal) - int'(motor_pos);
                dir_fwd = DIR_CW;
                if (span < 0)
                begin
                    span = -span;
                    dir_fwd = DIR_CCW;
                end
                span_wrap = span - REV;
                if (span_wrap < 0)
                    span_wrap = -span_wrap;
                // unchanged target keeps the old direction; a tie goes clockwise
                if (goal != motor_target)
                begin
                    if (span < span_wrap)
                        motor_dir = dir_fwd;
                    else if (span > span_wrap)
                        motor_dir = ~dir_fwd;
                    else
                        motor_dir = DIR_CW;
                end
                motor_target = goal;
                motor_armed = 1'b1;
                n_sets++;
            end
            OP_TICK:
            begin
                if (motor_armed && motor_target != motor_pos)
                begin
                    motor_pos = (motor_dir == DIR_CW) ? motor_pos + 9'd1 : motor_pos - 9'd1;
                    if (motor_pos == motor_target)
                        n_arrivals++;
                    n_moves++;
                    for (int k = 0; k < 4; k++)
                    begin
                        w.coils = (motor_dir == DIR_CW) ? (4'b1000 >> k) : (4'b0001 << k);
                        w.stepped = 1'b1;
                        w.position = motor_pos;
                        w.last = (k == 3);
                        coil_words_due.push_back(w);
                    end
                    return;
                end
            end
            OP_LOAD_POS:
                motor_pos = c.new_pos;
            default:
                motor_target = motor_pos;
        endcase
        w.position = motor_pos;
        coil_words_due.push_back(w);
    endtask

    // Mismatch report: one line each
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at word %0d: %s got %0d expected %0d", n_words, what, got, want);
    endtask

    // Driver: feeds pending commands, predicts at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= OP_SET_TARGET;
            send_wait <= 0;
            motor_pos = 9'd0;
            motor_target = 9'd0;
            motor_dir = DIR_CW;
            motor_armed = 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            predict_command(cur_cmd);
            n_cmds++;
            gap = draw_wait();
            if (gap == 0 && pending_cmds.size() > 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {6'd0, cur_cmd.new_pos, cur_cmd.angle};
                s_tuser <= cur_cmd.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
                send_wait <= gap;
            end
        end
        else if (!s_tvalid)
        begin
            if (send_wait > 0)
                send_wait <= send_wait - 1;
            else if (pending_cmds.size() > 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {6'd0, cur_cmd.new_pos, cur_cmd.angle};
                s_tuser <= cur_cmd.op;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: random backpressure, checks each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        coil_word_t w;
        int stall;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            n_words++;
            if (coil_words_due.size() == 0)
                report_mismatch("unexpected word, tdata", int'(m_tdata), 0);
            else
            begin
                w = coil_words_due.pop_front();
                if (m_tdata[3:0] !== w.coils)
                    report_mismatch("coils", int'(m_tdata[3:0]), int'(w.coils));
                if (m_tuser[0] !== w.stepped)
                    report_mismatch("stepped", int'(m_tuser[0]), int'(w.stepped));
                if (m_tdata[12:4] !== w.position)
                    report_mismatch("position", int'(m_tdata[12:4]), int'(w.position));
                if (m_tlast !== w.last)
                    report_mismatch("last", int'(m_tlast), int'(w.last));
            end
            stall = draw_wait();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                ready_wait <= stall;
            end
        end
        else if (!m_tready)
        begin
            if (ready_wait > 0)
                ready_wait <= ready_wait - 1;
            else
                m_tready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run limit of %0d cycles reached, %0d words outstanding",
                     CYCLE_LIMIT, coil_words_due.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_cmd(input op_t op, input int angle, input int new_pos);
        cmd_t c;
        c.op = op;
        c.angle = 9'(angle);
        c.new_pos = 9'(new_pos);
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    task automatic add_noise();
        add_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    // A trip: optional load near goal, set target, a run of ticks, optional target-at-position
    task automatic add_trip();
        int a;
        logic [8:0] goal;
        a = ($urandom_range(0, 7) == 0) ? $urandom_range(361, 511) : $urandom_range(0, 360);
        goal = angle_to_step(9'(a));
        if ($urandom_range(0, 2) != 0)
            add_cmd(OP_LOAD_POS, $urandom_range(0, 511),
                    int'(goal + 9'($urandom_range(0, 10)) - 9'd5));
        add_cmd(OP_SET_TARGET, a, $urandom_range(0, 511));
        repeat ($urandom_range(1, 9))
            add_cmd(OP_TICK, $urandom_range(0, 511), $urandom_range(0, 511));
        if ($urandom_range(0, 5) == 0)
            add_cmd(OP_TARGET_POS, $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    task automatic wait_queue_drained();
        while (pending_cmds.size() > 0 || s_tvalid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unarmed tick, unchanged target, tie, wraps both ways, field extremes
        add_cmd(OP_LOAD_POS, 0, 5);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_SET_TARGET, 0, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_TARGET_POS, 0, 0);
        add_cmd(OP_TICK, 511, 511);
        add_cmd(OP_LOAD_POS, 0, 0);
        add_cmd(OP_SET_TARGET, 180, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_LOAD_POS, 0, 0);
        add_cmd(OP_SET_TARGET, 1, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_LOAD_POS, 0, 511);
        add_cmd(OP_SET_TARGET, 359, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_SET_TARGET, 360, 511);
        add_cmd(OP_SET_TARGET, 511, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_SET_TARGET, 256, 0);
        add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_LOAD_POS, 511, 511);
        add_cmd(OP_TARGET_POS, 511, 511);
        add_cmd(OP_TICK, 511, 511);
        wait_queue_drained();

        // Random: mostly trips, some noise; the middle third runs with no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            calm = (phase == 1);
            while (n_queued < (phase + 1) * RANDOM_CMDS / 3)
            begin
                if ($urandom_range(0, 9) < 7)
                    add_trip();
                else
                    add_noise();
            end
            wait_queue_drained();
        end
        calm = 1'b0;

        while (coil_words_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("covered %0d commands: %0d target sets, %0d steps taken, %0d arrivals",
                 n_cmds, n_sets, n_moves, n_arrivals);
        $display("checked %0d output words, %0d mismatches", n_words, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
